// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the omni drive mixer RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define OMTW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define OMTW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/omtw_pkg.sv
`timescale 1ns / 1ps
// Package for the three-wheel omni drive mixer: widths, codes, reset values and types.
// No dependencies; used by every module of the block.
package omtw_pkg;

  // Field and register widths.
  localparam int STICK_W    = 8;
  localparam int COEF_W     = 16;
  localparam int DZ_W       = 8;
  localparam int GAIN_W     = 16;
  localparam int DUTY_W     = 8;
  localparam int DIR_W      = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_WHEELS = 3;

  // Datapath widths: one coefficient term, a wheel speed, its magnitude, the duty shift and the duty product.
  localparam int TERM_W     = COEF_W + STICK_W + 1;
  localparam int SPEED_W    = TERM_W + 2;
  localparam int MAG_W      = SPEED_W - 1;
  localparam int DUTY_SHIFT = 16;
  localparam int PROD_W     = MAG_W + GAIN_W;

  localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

  // Wheel bridge codes.
  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_DIAG = 3'd0,
    REG_COEF_SIDE = 3'd1,
    REG_COEF_TURN = 3'd2,
    REG_DZ_LINEAR = 3'd3,
    REG_DZ_TURN   = 3'd4,
    REG_DUTY_GAIN = 3'd5
  } cfg_idx_t;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic [COEF_W-1:0] coef_diag;
    logic [COEF_W-1:0] coef_side;
    logic [COEF_W-1:0] coef_turn;
    logic [DZ_W-1:0]   dz_linear;
    logic [DZ_W-1:0]   dz_turn;
    logic [GAIN_W-1:0] duty_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    coef_diag: 16'd4031,
    coef_side: 16'd2327,
    coef_turn: 16'd2063,
    dz_linear: 8'd21,
    dz_turn:   8'd6,
    duty_gain: 16'd255
  };

  // Speed of one wheel split into magnitude and bridge code.
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    dir_t             dir;
  } wheel_t;

endpackage

// File: hw/rtl/omtw_cfg.sv
`timescale 1ns / 1ps
// Configuration register file of the omni drive mixer.
// Depends on omtw_pkg for register indexes, widths and reset values.
module omtw_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [omtw_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [omtw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output omtw_pkg::cfg_t                      cfg_o
);

  omtw_pkg::cfg_t cfg_r;
  omtw_pkg::cfg_t cfg_nxt;

  // Decode the write; indexes beyond the list leave everything unchanged.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (omtw_pkg::cfg_idx_t'(cfg_addr))
        omtw_pkg::REG_COEF_DIAG: cfg_nxt.coef_diag = cfg_wdata[omtw_pkg::COEF_W-1:0];
        omtw_pkg::REG_COEF_SIDE: cfg_nxt.coef_side = cfg_wdata[omtw_pkg::COEF_W-1:0];
        omtw_pkg::REG_COEF_TURN: cfg_nxt.coef_turn = cfg_wdata[omtw_pkg::COEF_W-1:0];
        omtw_pkg::REG_DZ_LINEAR: cfg_nxt.dz_linear = cfg_wdata[omtw_pkg::DZ_W-1:0];
        omtw_pkg::REG_DZ_TURN:   cfg_nxt.dz_turn   = cfg_wdata[omtw_pkg::DZ_W-1:0];
        omtw_pkg::REG_DUTY_GAIN: cfg_nxt.duty_gain = cfg_wdata[omtw_pkg::GAIN_W-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register storage with reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= omtw_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// File: hw/rtl/omtw_mix.sv
`timescale 1ns / 1ps
// Front of the mixer pipeline: deadzone, coefficient products and wheel speed sums.
// Depends on omtw_pkg and assert_macros.svh; three register stages.
`include "assert_macros.svh"
module omtw_mix (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      valid_i,
  input  logic signed [omtw_pkg::STICK_W-1:0]       lx_i,
  input  logic signed [omtw_pkg::STICK_W-1:0]       ly_i,
  input  logic signed [omtw_pkg::STICK_W-1:0]       rx_i,
  input  omtw_pkg::cfg_t                            cfg_i,
  output logic                                      valid_o,
  output omtw_pkg::wheel_t [omtw_pkg::NUM_WHEELS-1:0] wheels_o
);

  localparam int SW = omtw_pkg::STICK_W;
  localparam int TW = omtw_pkg::TERM_W;
  localparam int PW = omtw_pkg::SPEED_W;
  localparam int MW = omtw_pkg::MAG_W;

  // Zero a stick value whose magnitude is at or below the zone; -128 counts as 128.
  function automatic logic signed [SW-1:0] deadzone(input logic signed [SW-1:0] v,
                                                    input logic [omtw_pkg::DZ_W-1:0] zone);
    logic [SW:0] mag;
    mag = v[SW-1] ? ((SW+1)'(0) - {v[SW-1], v}) : {1'b0, v};
    return (mag <= (SW+1)'(zone)) ? '0 : v;
  endfunction

  // Split a signed speed into magnitude and bridge code.
  function automatic omtw_pkg::wheel_t to_wheel(input logic signed [PW-1:0] sp);
    omtw_pkg::wheel_t w;
    w.mag = sp[PW-1] ? MW'(-sp) : MW'(sp);
    if (sp[PW-1]) begin
      w.dir = omtw_pkg::DIR_REV;
    end else if (sp != '0) begin
      w.dir = omtw_pkg::DIR_FWD;
    end else begin
      w.dir = omtw_pkg::DIR_STOP;
    end
    return w;
  endfunction

  // Stage one: deadzoned stick values.
  logic                 s1_valid_r;
  logic signed [SW-1:0] s1_lx_r;
  logic signed [SW-1:0] s1_ly_r;
  logic signed [SW-1:0] s1_rx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    s1_lx_r <= deadzone(lx_i, cfg_i.dz_linear);
    s1_ly_r <= deadzone(ly_i, cfg_i.dz_linear);
    s1_rx_r <= deadzone(rx_i, cfg_i.dz_turn);
  end

  // Stage two: one exact signed product per axis.
  logic signed [omtw_pkg::COEF_W:0] diag_c;
  logic signed [omtw_pkg::COEF_W:0] side_c;
  logic signed [omtw_pkg::COEF_W:0] turn_c;
  logic signed [TW-1:0]             s2_diag_nxt;
  logic signed [TW-1:0]             s2_side_nxt;
  logic signed [TW-1:0]             s2_turn_nxt;
  logic                             s2_valid_r;
  logic signed [TW-1:0]             s2_diag_r;
  logic signed [TW-1:0]             s2_side_r;
  logic signed [TW-1:0]             s2_turn_r;

  assign diag_c = $signed({1'b0, cfg_i.coef_diag});
  assign side_c = $signed({1'b0, cfg_i.coef_side});
  assign turn_c = $signed({1'b0, cfg_i.coef_turn});

  always_comb begin
    s2_diag_nxt = TW'(diag_c) * TW'(s1_ly_r);
    s2_side_nxt = TW'(side_c) * TW'(s1_lx_r);
    s2_turn_nxt = TW'(turn_c) * TW'(s1_rx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_diag_r <= s2_diag_nxt;
    s2_side_r <= s2_side_nxt;
    s2_turn_r <= s2_turn_nxt;
  end

  // Stage three: wheel speed sums, then magnitude and direction.
  logic signed [PW-1:0]                               diag_x;
  logic signed [PW-1:0]                               side_x;
  logic signed [PW-1:0]                               turn_x;
  logic signed [PW-1:0]                               speed1;
  logic signed [PW-1:0]                               speed2;
  logic signed [PW-1:0]                               speed3;
  omtw_pkg::wheel_t [omtw_pkg::NUM_WHEELS-1:0]        s3_wheels_nxt;
  logic                                               s3_valid_r;
  omtw_pkg::wheel_t [omtw_pkg::NUM_WHEELS-1:0]        s3_wheels_r;

  always_comb begin
    diag_x = PW'(s2_diag_r);
    side_x = PW'(s2_side_r);
    turn_x = PW'(s2_turn_r);
    speed1 = turn_x + side_x - diag_x;
    speed2 = turn_x - (side_x <<< 1);
    speed3 = turn_x + side_x + diag_x;
    s3_wheels_nxt[0] = to_wheel(speed1);
    s3_wheels_nxt[1] = to_wheel(speed2);
    s3_wheels_nxt[2] = to_wheel(speed3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_wheels_r <= s3_wheels_nxt;
  end

  assign valid_o  = s3_valid_r;
  assign wheels_o = s3_wheels_r;

  // Wheels one and two stop exactly when their speed magnitude is zero.
  `OMTW_ASSERT_IMP(a_stop_w1, s3_valid_r,
    (s3_wheels_r[0].dir == omtw_pkg::DIR_STOP) == (s3_wheels_r[0].mag == '0),
    "wheel one direction disagrees with its speed magnitude")
  `OMTW_ASSERT_IMP(a_stop_w2, s3_valid_r,
    (s3_wheels_r[1].dir == omtw_pkg::DIR_STOP) == (s3_wheels_r[1].mag == '0),
    "wheel two direction disagrees with its speed magnitude")

endmodule

// File: hw/rtl/omtw_duty.sv
`timescale 1ns / 1ps
// Back of the mixer pipeline: duty product and saturation for all three wheels.
// Depends on omtw_pkg and assert_macros.svh; two register stages.
`include "assert_macros.svh"
module omtw_duty (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        valid_i,
  input  omtw_pkg::wheel_t [omtw_pkg::NUM_WHEELS-1:0] wheels_i,
  input  logic [omtw_pkg::GAIN_W-1:0]                 gain_i,
  output logic                                        valid_o,
  output logic [omtw_pkg::NUM_WHEELS-1:0][omtw_pkg::DUTY_W-1:0] duty_o,
  output omtw_pkg::dir_t [omtw_pkg::NUM_WHEELS-1:0]   dir_o
);

  localparam int NW  = omtw_pkg::NUM_WHEELS;
  localparam int RW  = omtw_pkg::PROD_W;
  localparam int DW  = omtw_pkg::DUTY_W;
  localparam int SH  = omtw_pkg::DUTY_SHIFT;

  // Stage four: magnitude times gain, one multiplier per wheel.
  logic                               s4_valid_r;
  logic [NW-1:0][RW-1:0]              s4_prod_r;
  omtw_pkg::dir_t [NW-1:0]            s4_dir_r;

  // Stage five: shifted and saturated duty.
  logic [NW-1:0][DW-1:0]              s5_duty_nxt;
  logic                               s5_valid_r;
  logic [NW-1:0][DW-1:0]              s5_duty_r;
  omtw_pkg::dir_t [NW-1:0]            s5_dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= valid_i;
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NW; i++) begin
      s4_prod_r[i] <= RW'(wheels_i[i].mag) * RW'(gain_i);
      s4_dir_r[i]  <= wheels_i[i].dir;
    end
  end

  // Any bit above the duty field after the shift means saturation.
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      if (s4_prod_r[i][RW-1:SH+DW] != '0) begin
        s5_duty_nxt[i] = omtw_pkg::DUTY_MAX;
      end else begin
        s5_duty_nxt[i] = s4_prod_r[i][SH+DW-1:SH];
      end
    end
  end

  always_ff @(posedge clk) begin
    s5_duty_r <= s5_duty_nxt;
    s5_dir_r  <= s4_dir_r;
  end

  assign valid_o = s5_valid_r;
  assign duty_o  = s5_duty_r;
  assign dir_o   = s5_dir_r;

  // Wheel three, when stopped, can only carry zero duty.
  `OMTW_ASSERT_IMP(a_stop_zero_duty,
    s5_valid_r && (s5_dir_r[2] == omtw_pkg::DIR_STOP),
    s5_duty_r[2] == '0,
    "wheel three stopped with nonzero duty")

endmodule

// File: hw/rtl/omni_three_wheel_drive_mixer.sv
`timescale 1ns / 1ps
// Top level of the three-wheel omni drive mixer.
// Depends on omtw_pkg, omtw_cfg, omtw_mix, omtw_duty and assert_macros.svh.
//
//   Channel   Ports                          Handshake
//   input     in_stick_lx/ly/rx              start, taken when busy is low
//   result    out_wheel1..3_duty/_dir        out_valid strobe, one cycle
//   config    cfg_we, cfg_addr, cfg_wdata    written at a rising edge with cfg_we, outside reset
//
// One request can enter every cycle while busy is low; its result passes through
// the five register stages (deadzone, products, sums, duty product, saturation).
// Reset is synchronous and active low; it clears the pipeline valid bits and
// loads the register defaults. busy is high only while reset is held.
// The result side cannot stall, so the pipeline never holds an item back.
`include "assert_macros.svh"
module omni_three_wheel_drive_mixer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [omtw_pkg::STICK_W-1:0]  in_stick_lx,
  input  logic signed [omtw_pkg::STICK_W-1:0]  in_stick_ly,
  input  logic signed [omtw_pkg::STICK_W-1:0]  in_stick_rx,
  output logic                                 out_valid,
  output logic [omtw_pkg::DUTY_W-1:0]          out_wheel1_duty,
  output logic [omtw_pkg::DIR_W-1:0]           out_wheel1_dir,
  output logic [omtw_pkg::DUTY_W-1:0]          out_wheel2_duty,
  output logic [omtw_pkg::DIR_W-1:0]           out_wheel2_dir,
  output logic [omtw_pkg::DUTY_W-1:0]          out_wheel3_duty,
  output logic [omtw_pkg::DIR_W-1:0]           out_wheel3_dir,
  input  logic                                 cfg_we,
  input  logic [omtw_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [omtw_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  omtw_pkg::cfg_t                                     cfg;
  logic                                               accept;
  logic                                               mix_valid;
  omtw_pkg::wheel_t [omtw_pkg::NUM_WHEELS-1:0]        mix_wheels;
  logic [omtw_pkg::NUM_WHEELS-1:0][omtw_pkg::DUTY_W-1:0] duty;
  omtw_pkg::dir_t [omtw_pkg::NUM_WHEELS-1:0]          dir;

  // Requests are refused only while reset is held.
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  omtw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  omtw_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (accept),
    .lx_i     (in_stick_lx),
    .ly_i     (in_stick_ly),
    .rx_i     (in_stick_rx),
    .cfg_i    (cfg),
    .valid_o  (mix_valid),
    .wheels_o (mix_wheels)
  );

  omtw_duty u_duty (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (mix_valid),
    .wheels_i (mix_wheels),
    .gain_i   (cfg.duty_gain),
    .valid_o  (out_valid),
    .duty_o   (duty),
    .dir_o    (dir)
  );

  // Result ports.
  assign out_wheel1_duty = duty[0];
  assign out_wheel1_dir  = dir[0];
  assign out_wheel2_duty = duty[1];
  assign out_wheel2_dir  = dir[1];
  assign out_wheel3_duty = duty[2];
  assign out_wheel3_dir  = dir[2];

  // Every accepted request gives exactly one result strobe, and no strobe comes without one.
  `OMTW_ASSERT_NXT(a_latency, 1'b1, out_valid == $past(accept, 5),
    "result strobe does not match an accepted request five cycles earlier")

endmodule
